// ===== sv/mfde_pkg.sv =====
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared types and constants of the monochrome frame store draw engine.
// ----------------------------------------------------------------------------
package mfde_pkg;

	localparam int ScreenWidth  = 128;
	localparam int ScreenHeight = 64;
	localparam int RowBytes     = (ScreenWidth + 7) / 8;
	localparam int StoreBytes   = RowBytes * ScreenHeight;
	localparam int AddrW        = $clog2(StoreBytes);
	localparam int ColW         = $clog2(RowBytes);
	localparam int RowW         = $clog2(ScreenHeight);

	localparam logic [3:0] KIND_CLEAR  = 4'd0;
	localparam logic [3:0] KIND_PIXEL  = 4'd1;
	localparam logic [3:0] KIND_HLINE  = 4'd2;
	localparam logic [3:0] KIND_VLINE  = 4'd3;
	localparam logic [3:0] KIND_RECT   = 4'd4;
	localparam logic [3:0] KIND_FILL   = 4'd5;
	localparam logic [3:0] KIND_DISC   = 4'd6;
	localparam logic [3:0] KIND_GLYPH  = 4'd7;
	localparam logic [3:0] KIND_RDPIX  = 4'd8;
	localparam logic [3:0] KIND_RDBYTE = 4'd9;

	// one byte-wide access request from the rasterizer to the store
	typedef struct packed {
		logic             wr;
		logic [AddrW-1:0] addr;
		logic [7:0]       mask;
	} store_req_t;

	// font column for glyph index 0..7 and column 0..4; index 7 is blank
	function automatic logic [6:0] font_col(input logic [2:0] idx, input logic [2:0] col);
		logic [6:0] c;
		c = 7'h00;
		case (idx)
			3'd0: case (col) 3'd2: c = 7'h7F; default: c = 7'h01; endcase
			3'd1: case (col) 3'd0, 3'd4: c = 7'h7F; default: c = 7'h08; endcase
			3'd2: case (col) 3'd0: c = 7'h7F; 3'd4: c = 7'h41; default: c = 7'h49; endcase
			3'd3: case (col) 3'd0: c = 7'h7F; 3'd4: c = 7'h36; default: c = 7'h49; endcase
			3'd4: case (col) 3'd0, 3'd4: c = 7'h3F; default: c = 7'h40; endcase
			3'd5: case (col) 3'd0, 3'd4: c = 7'h3E; default: c = 7'h41; endcase
			3'd6: case (col)
				3'd0, 3'd4: c = 7'h7F;
				3'd1: c = 7'h02;
				3'd2: c = 7'h04;
				default: c = 7'h08;
			endcase
			default: c = 7'h00;
		endcase
		if (col > 3'd4) c = 7'h00;
		return c;
	endfunction

	// glyph index from character code; 7 means blank or unknown
	function automatic logic [2:0] font_index(input logic [7:0] code);
		logic [2:0] i;
		case (code)
			8'h54: i = 3'd0;
			8'h48: i = 3'd1;
			8'h45: i = 3'd2;
			8'h42: i = 3'd3;
			8'h55: i = 3'd4;
			8'h4F: i = 3'd5;
			8'h4E: i = 3'd6;
			default: i = 3'd7;
		endcase
		return i;
	endfunction

endpackage

// ===== sv/mfde_store.sv =====
// ----------------------------------------------------------------------------
// mfde_store
// Frame store memory with a read-modify-write port, a clearing sweep and a
// registered read.
// ----------------------------------------------------------------------------
module mfde_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  mfde_pkg::store_req_t      req,
	input  logic                      clr_valid,
	input  logic [mfde_pkg::AddrW-1:0] clr_addr,
	output logic [7:0]                rd_data
);
	logic [7:0] mem [mfde_pkg::StoreBytes];
	logic [7:0] rdata_q;
	logic       wr_s1;
	logic       clr_s1;
	logic [mfde_pkg::AddrW-1:0] addr_s1;
	logic [7:0] mask_s1;
	logic       fwd;
	logic [7:0] cur;

	// forward the byte just written when the next access hits it
	logic [7:0] last_q;
	logic [mfde_pkg::AddrW-1:0] last_addr_q;
	logic       last_v_q;

	always_ff @(posedge clk) begin
		rdata_q <= mem[clr_valid ? clr_addr : req.addr];
		if (clr_s1) begin
			mem[addr_s1] <= 8'h00;
		end else if (wr_s1) begin
			mem[addr_s1] <= cur | mask_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1    <= 1'b0;
			clr_s1   <= 1'b0;
			last_v_q <= 1'b0;
		end else begin
			wr_s1    <= req_valid && req.wr && !clr_valid;
			clr_s1   <= clr_valid;
			last_v_q <= wr_s1 || clr_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1     <= clr_valid ? clr_addr : req.addr;
		mask_s1     <= req.mask;
		last_q      <= clr_s1 ? 8'h00 : (cur | mask_s1);
		last_addr_q <= addr_s1;
	end

	assign fwd     = last_v_q && (last_addr_q == addr_s1);
	assign cur     = fwd ? last_q : rdata_q;
	assign rd_data = cur;

endmodule

// ===== sv/mono_framebuffer_draw_engine.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// 1 bit per pixel frame store with a byte-wide drawing sequencer.
// ----------------------------------------------------------------------------
// Input channel: one command per transaction (kind plus operands) on
// in_valid/in_stall. Output channel: exactly one read_value per command on
// out_valid/out_stall, in command order.
// The store is 8 pixels per byte, row-major, MSB leftmost, kept in one
// synchronous RAM that is read, modified and written back one byte a cycle.
// A drawing command scans the clipped bounding box of its shape, position
// by position: per pixel for lines, discs and glyphs, per store byte for
// rows of a filled rectangle, and only the edge columns on inner rows of an
// outline. Empty shapes and unused kinds skip the scan, reads pass ST_RD1
// and ST_RD2, and a clear sweeps all StoreBytes (1024) bytes. ST_DONE then
// passes the result on, and the next command is taken once idle with no
// result pending. The single store port limits the scan. After reset the
// same sweep runs before the first command.
// The result waits in an output register; while the receiver stalls, the
// next command is still executed, and only the one after that waits.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [3:0]        kind,
	input  logic signed [10:0] pos_x,
	input  logic signed [10:0] pos_y,
	input  logic signed [10:0] end_x,
	input  logic signed [10:0] end_y,
	input  logic [9:0]        size_w,
	input  logic [9:0]        size_h,
	input  logic [5:0]        radius,
	input  logic [7:0]        glyph_code,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        read_value
);
	localparam int AW = mfde_pkg::AddrW;

	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_DRAW, ST_RD1, ST_RD2, ST_DONE} state_t;
	// sub-passes of a shape: generic x/y scan over a box with per-pixel test
	state_t state_q;

	logic [3:0]  kind_q;
	logic signed [12:0] bx0_q, bx1_q, by0_q, by1_q; // box bounds (inclusive)
	logic signed [12:0] cx_q, cy_q;                 // scan position
	logic signed [12:0] ox_q, oy_q;                 // origin of shape
	logic signed [12:0] ex_q, ey_q;                 // far corner of rect
	logic [12:0] rr_q;
	logic [2:0]  gidx_q;
	logic [7:0]  rbyte_q;
	logic        rpix_q;
	logic [AW-1:0] clr_cnt_q;
	logic        res_pending_q;
	logic [7:0]  res_q;
	logic        out_valid_q;
	logic [7:0]  out_q;

	mfde_pkg::store_req_t req;
	logic        req_valid;
	logic [7:0]  rd_data;
	logic        clr_valid;

	// pixel test of current scan position
	logic signed [12:0] dx, dy;
	logic signed [12:0] ax, ay;
	logic [25:0] d2;
	logic        hit, onscr, last_x, last_y;
	logic [12:0] xu, yu;
	logic signed [12:0] fx1;
	logic [6:0]  gcol;
	logic [7:0]  span_mask;
	logic        fill_mode;

	always_comb begin
		dx   = cx_q - ox_q;
		dy   = cy_q - oy_q;
		ax   = dx[12] ? -dx : dx;
		ay   = dy[12] ? -dy : dy;
		d2   = 26'(12'(ax[5:0]) * 12'(ax[5:0])) + 26'(12'(ay[5:0]) * 12'(ay[5:0]));
		gcol = mfde_pkg::font_col(gidx_q, dx[2:0]);
		onscr = cx_q >= 0 && cx_q < mfde_pkg::ScreenWidth && cy_q >= 0
			&& cy_q < mfde_pkg::ScreenHeight;
		fill_mode = kind_q == mfde_pkg::KIND_FILL;
		case (kind_q)
			mfde_pkg::KIND_RECT:  hit = cx_q == ox_q || cx_q == ex_q || cy_q == oy_q || cy_q == ey_q;
			mfde_pkg::KIND_DISC:  hit = d2 <= 26'(rr_q);
			mfde_pkg::KIND_GLYPH: hit = gcol[dy[2:0]];
			default:              hit = 1'b1;
		endcase
		// rect outline: inner pixels skipped by jumping; here just test
		fx1    = {cx_q[12:3], 3'b111};
		last_x = fill_mode ? (fx1 >= bx1_q) : (cx_q >= bx1_q);
		last_y = cy_q >= by1_q;
		xu = cx_q;
		yu = cy_q;
		for (int i = 0; i < 8; i++) begin
			span_mask[7-i] = ({cx_q[12:3], 3'(i)} >= bx0_q) && ({cx_q[12:3], 3'(i)} <= bx1_q);
		end
	end

	assign clr_valid = state_q == ST_CLEAR;
	assign req_valid = (state_q == ST_DRAW && onscr && hit) || state_q == ST_IDLE;
	always_comb begin
		req.wr   = state_q == ST_DRAW;
		req.addr = AW'(yu[mfde_pkg::RowW-1:0] * mfde_pkg::RowBytes)
			+ AW'(xu[12:3]);
		req.mask = fill_mode ? span_mask : (8'h80 >> xu[2:0]);
		if (state_q == ST_IDLE) begin
			req.addr = AW'(11'(pos_y) * mfde_pkg::RowBytes) + AW'(pos_x[10:3]);
		end
	end

	mfde_store u_store (
		.clk, .arst_n,
		.req_valid, .req,
		.clr_valid, .clr_addr (clr_cnt_q),
		.rd_data
	);

	logic accept;
	logic onscr_in;
	logic signed [12:0] sx, sy, sex, sey, a0, a1, b0, b1;
	assign accept = in_valid && !in_stall;
	assign in_stall = state_q != ST_IDLE || res_pending_q;
	assign onscr_in = pos_x >= 0 && pos_x < mfde_pkg::ScreenWidth && pos_y >= 0
		&& pos_y < mfde_pkg::ScreenHeight;

	always_comb begin
		sx  = 13'(pos_x);
		sy  = 13'(pos_y);
		sex = 13'(end_x);
		sey = 13'(end_y);
		a0 = sx; a1 = sx; b0 = sy; b1 = sy;
		case (kind)
			mfde_pkg::KIND_HLINE: begin
				a0 = sx < sex ? sx : sex; a1 = sx < sex ? sex : sx;
			end
			mfde_pkg::KIND_VLINE: begin
				b0 = sy < sey ? sy : sey; b1 = sy < sey ? sey : sy;
			end
			mfde_pkg::KIND_RECT, mfde_pkg::KIND_FILL: begin
				a1 = sx + 13'(size_w) - 13'sd1; b1 = sy + 13'(size_h) - 13'sd1;
			end
			mfde_pkg::KIND_DISC: begin
				a0 = sx - 13'(radius); a1 = sx + 13'(radius);
				b0 = sy - 13'(radius); b1 = sy + 13'(radius);
			end
			mfde_pkg::KIND_GLYPH: begin
				a1 = sx + 13'sd4; b1 = sy + 13'sd6;
			end
			default: ;
		endcase
		// clip box to screen
		if (a0 < 0) a0 = '0;
		if (b0 < 0) b0 = '0;
		if (a1 > mfde_pkg::ScreenWidth - 1) a1 = 13'(mfde_pkg::ScreenWidth - 1);
		if (b1 > mfde_pkg::ScreenHeight - 1) b1 = 13'(mfde_pkg::ScreenHeight - 1);
	end

	logic empty;
	assign empty = a0 > a1 || b0 > b1
		|| ((kind == mfde_pkg::KIND_RECT || kind == mfde_pkg::KIND_FILL)
			&& (size_w == '0 || size_h == '0))
		|| (kind == mfde_pkg::KIND_GLYPH && mfde_pkg::font_index(glyph_code) == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_cnt_q     <= '0;
			res_pending_q <= 1'b0;
			out_valid_q   <= 1'b0;
			kind_q        <= mfde_pkg::KIND_PIXEL;
			cx_q          <= '0;
			cy_q          <= '0;
		end else begin
			if (res_pending_q && (!out_valid_q || !out_stall)) begin
				out_valid_q   <= 1'b1;
				res_pending_q <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (clr_cnt_q == AW'(mfde_pkg::StoreBytes - 1)) begin
						clr_cnt_q <= '0;
						state_q   <= kind_q == mfde_pkg::KIND_CLEAR ? ST_DONE : ST_IDLE;
					end else begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
					end
				end
				ST_IDLE: if (accept) begin
					kind_q <= kind;
					cx_q   <= kind == mfde_pkg::KIND_FILL ? {a0[12:3], 3'b000} : a0;
					cy_q   <= b0;
					case (kind)
						mfde_pkg::KIND_CLEAR: state_q <= ST_CLEAR;
						mfde_pkg::KIND_RDPIX, mfde_pkg::KIND_RDBYTE: state_q <= ST_RD1;
						mfde_pkg::KIND_PIXEL, mfde_pkg::KIND_HLINE, mfde_pkg::KIND_VLINE,
						mfde_pkg::KIND_RECT, mfde_pkg::KIND_FILL, mfde_pkg::KIND_DISC,
						mfde_pkg::KIND_GLYPH: state_q <= empty ? ST_DONE : ST_DRAW;
						default: state_q <= ST_DONE;
					endcase
				end
				ST_DRAW: begin
					if (last_x) begin
						cx_q <= fill_mode ? {bx0_q[12:3], 3'b000} : bx0_q;
						cy_q <= cy_q + 13'sd1;
						if (last_y) state_q <= ST_DONE;
					end else if (fill_mode) begin
						cx_q <= fx1 + 13'sd1;
					end else if (kind_q == mfde_pkg::KIND_RECT && cy_q != by0_q
						&& cy_q != by1_q && cx_q == bx0_q) begin
						// skip the inside of an outline row
						cx_q <= bx1_q;
					end else begin
						cx_q <= cx_q + 13'sd1;
					end
				end
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q       <= ST_IDLE;
					res_pending_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bx0_q  <= a0;
			bx1_q  <= a1;
			by0_q  <= b0;
			by1_q  <= b1;
			ox_q   <= 13'(pos_x);
			oy_q   <= 13'(pos_y);
			ex_q   <= 13'(pos_x) + 13'(size_w) - 13'sd1;
			ey_q   <= 13'(pos_y) + 13'(size_h) - 13'sd1;
			rr_q   <= 13'(radius) * 13'(radius);
			gidx_q <= mfde_pkg::font_index(glyph_code);
			rpix_q <= onscr_in;
			rbyte_q <= 8'h80 >> pos_x[2:0];
		end
		if (state_q == ST_RD2) begin
			if (!rpix_q || kind_q != mfde_pkg::KIND_RDPIX && kind_q != mfde_pkg::KIND_RDBYTE)
				res_q <= 8'h00;
			else if (kind_q == mfde_pkg::KIND_RDBYTE)
				res_q <= rd_data;
			else
				res_q <= {7'd0, |(rd_data & rbyte_q)};
		end else if (state_q == ST_IDLE && accept) begin
			res_q <= 8'h00;
		end
		if (res_pending_q && (!out_valid_q || !out_stall)) out_q <= res_q;
	end

	assign out_valid  = out_valid_q;
	assign read_value = out_q;

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> res_pending_q) else $error("result lost");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall) else $error("took command while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value)) else $error("result dropped");

endmodule

// ===== tb/mono_framebuffer_draw_engine_tb.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine_tb
// Drives draw and read commands into the frame store engine under several
// idle and stall patterns, keeps its own copy of the store to predict every
// read value, and compares each output transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mono_framebuffer_draw_engine_tb;

	localparam int WatchdogLimit = 200000;
	localparam int DrainCycles   = 3000;
	localparam logic [63:0] FontChars = "THEBUON ";

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [3:0]        kind;
	logic signed [10:0] pos_x;
	logic signed [10:0] pos_y;
	logic signed [10:0] end_x;
	logic signed [10:0] end_y;
	logic [9:0]        size_w;
	logic [9:0]        size_h;
	logic [5:0]        radius;
	logic [7:0]        glyph_code;
	logic              out_valid;
	logic              out_stall;
	logic [7:0]        read_value;

	logic [7:0] shadow_store [mfde_pkg::StoreBytes];
	logic [7:0] expected_values [$];
	int         mismatch_count;
	int         idle_pct;
	int         stall_pct;
	bit         hold_off;
	int         quiet_cycles;

	mono_framebuffer_draw_engine u_dut (.*);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// ------------------------------------------------------------------ model
	function automatic bit on_screen(int x, int y);
		return x >= 0 && x < mfde_pkg::ScreenWidth && y >= 0 && y < mfde_pkg::ScreenHeight;
	endfunction

	function automatic int store_offset(int x, int y);
		return y * mfde_pkg::RowBytes + x / 8;
	endfunction

	function automatic void plot(int x, int y);
		if (on_screen(x, y))
			shadow_store[store_offset(x, y)][7 - (x % 8)] = 1'b1;
	endfunction

	function automatic void span_h(int x0, int x1, int y);
		int t;
		if (x0 > x1) begin
			t = x0; x0 = x1; x1 = t;
		end
		for (int x = x0; x <= x1; x++)
			plot(x, y);
	endfunction

	function automatic void span_v(int x, int y0, int y1);
		int t;
		if (y0 > y1) begin
			t = y0; y0 = y1; y1 = t;
		end
		for (int y = y0; y <= y1; y++)
			plot(x, y);
	endfunction

	function automatic logic [6:0] glyph_column(logic [7:0] code, int c);
		logic [34:0] bits;
		case (code)
			"T": bits = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
			"H": bits = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
			"E": bits = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
			"B": bits = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h36};
			"U": bits = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
			"O": bits = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
			"N": bits = {7'h7F, 7'h02, 7'h04, 7'h08, 7'h7F};
			default: bits = '0;
		endcase
		return bits[(4 - c) * 7 +: 7];
	endfunction

	// apply one command to the shadow store and return its read value
	function automatic logic [7:0] execute_command(logic [3:0] k, int px, int py, int ex,
			int ey, int w, int h, int r, logic [7:0] code);
		logic [7:0] v;
		logic [6:0] col;
		v = '0;
		case (k)
			mfde_pkg::KIND_CLEAR:
				for (int i = 0; i < mfde_pkg::StoreBytes; i++) shadow_store[i] = '0;
			mfde_pkg::KIND_PIXEL: plot(px, py);
			mfde_pkg::KIND_HLINE: if (py >= 0 && py < mfde_pkg::ScreenHeight) span_h(px, ex, py);
			mfde_pkg::KIND_VLINE: if (px >= 0 && px < mfde_pkg::ScreenWidth) span_v(px, py, ey);
			mfde_pkg::KIND_RECT: if (w > 0 && h > 0) begin
				span_h(px, px + w - 1, py);
				span_h(px, px + w - 1, py + h - 1);
				span_v(px, py, py + h - 1);
				span_v(px + w - 1, py, py + h - 1);
			end
			mfde_pkg::KIND_FILL: if (w > 0 && h > 0) begin
				for (int y = py; y < py + h; y++)
					if (y >= 0 && y < mfde_pkg::ScreenHeight) span_h(px, px + w - 1, y);
			end
			mfde_pkg::KIND_DISC: for (int dy = -r; dy <= r; dy++)
				for (int dx = -r; dx <= r; dx++)
					if (dx * dx + dy * dy <= r * r) plot(px + dx, py + dy);
			mfde_pkg::KIND_GLYPH: for (int c = 0; c < 5; c++) begin
				col = glyph_column(code, c);
				for (int row = 0; row < 7; row++)
					if (col[row]) plot(px + c, py + row);
			end
			mfde_pkg::KIND_RDPIX: if (on_screen(px, py))
				v = {7'b0, shadow_store[store_offset(px, py)][7 - (px % 8)]};
			mfde_pkg::KIND_RDBYTE: if (on_screen(px, py)) v = shadow_store[store_offset(px, py)];
			default: ;
		endcase
		return v;
	endfunction

	// -------------------------------------------------------------- stimulus
	task automatic send_command(logic [3:0] k, int px, int py, int ex = 0, int ey = 0,
			int w = 0, int h = 0, int r = 0, int code = 0);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		pos_x      <= px[10:0];
		pos_y      <= py[10:0];
		end_x      <= ex[10:0];
		end_y      <= ey[10:0];
		size_w     <= w[9:0];
		size_h     <= h[9:0];
		radius     <= r[5:0];
		glyph_code <= code[7:0];
		expected_values.push_back(execute_command(k, int'($signed(px[10:0])),
			int'($signed(py[10:0])), int'($signed(ex[10:0])), int'($signed(ey[10:0])),
			int'(w[9:0]), int'(h[9:0]), int'(r[5:0]), code[7:0]));
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	function automatic int near_coord(int span);
		case ($urandom_range(9))
			0: return $urandom_range(2047) - 1024;
			1: return -$urandom_range(20);
			2: return span + $urandom_range(20);
			default: return $urandom_range(span - 1);
		endcase
	endfunction

	task automatic send_random_command();
		logic [3:0] k;
		int pick;
		int code;
		pick = $urandom_range(99);
		if (pick < 2) k = mfde_pkg::KIND_CLEAR;
		else if (pick < 25) k = mfde_pkg::KIND_RDBYTE;
		else if (pick < 35) k = mfde_pkg::KIND_RDPIX;
		else if (pick < 37) k = 4'(10 + $urandom_range(5));
		else k = 4'(mfde_pkg::KIND_PIXEL + $urandom_range(6));
		if ($urandom_range(3) == 0)
			code = $urandom_range(255);
		else
			code = int'(FontChars[8 * $urandom_range(7) +: 8]);
		// sizes mostly small; occasionally the full field range
		if ($urandom_range(19) == 0)
			send_command(k, $urandom_range(2047) - 1024, $urandom_range(2047) - 1024,
				$urandom_range(2047) - 1024, $urandom_range(2047) - 1024,
				$urandom_range(1023), $urandom_range(1023), $urandom_range(63),
				$urandom_range(255));
		else
			send_command(k, near_coord(mfde_pkg::ScreenWidth), near_coord(mfde_pkg::ScreenHeight),
				near_coord(mfde_pkg::ScreenWidth), near_coord(mfde_pkg::ScreenHeight),
				$urandom_range(24), $urandom_range(16), $urandom_range(12), code);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (expected_values.size() != 0);
	endtask

	task automatic read_back_rows(int n);
		for (int i = 0; i < n; i++)
			send_command(mfde_pkg::KIND_RDBYTE, $urandom_range(mfde_pkg::ScreenWidth - 1),
				$urandom_range(mfde_pkg::ScreenHeight - 1));
	endtask

	task automatic test_directed();
		send_command(mfde_pkg::KIND_RDBYTE, 0, 0);
		send_command(mfde_pkg::KIND_PIXEL, 0, 0);
		send_command(mfde_pkg::KIND_PIXEL, mfde_pkg::ScreenWidth - 1, mfde_pkg::ScreenHeight - 1);
		send_command(mfde_pkg::KIND_PIXEL, -1, 5);
		send_command(mfde_pkg::KIND_HLINE, 140, 3, -20);
		send_command(mfde_pkg::KIND_VLINE, 9, 70, 0, -1024);
		send_command(mfde_pkg::KIND_RECT, -3, -3, 0, 0, 1023, 1023);
		send_command(mfde_pkg::KIND_RECT, 30, 30, 0, 0, 0, 5);
		send_command(mfde_pkg::KIND_FILL, 13, 40, 0, 0, 11, 3);
		send_command(mfde_pkg::KIND_FILL, 50, 10, 0, 0, 5, 0);
		send_command(mfde_pkg::KIND_DISC, 100, 30, 0, 0, 0, 0, 63);
		send_command(mfde_pkg::KIND_DISC, 60, 20, 0, 0, 0, 0, 0);
		send_command(mfde_pkg::KIND_GLYPH, 70, 50, 0, 0, 0, 0, 0, "B");
		send_command(mfde_pkg::KIND_GLYPH, 124, 60, 0, 0, 0, 0, 0, "N");
		send_command(mfde_pkg::KIND_GLYPH, 80, 50, 0, 0, 0, 0, 0, 8'hFF);
		send_command(mfde_pkg::KIND_RDPIX, 71, 52);
		send_command(mfde_pkg::KIND_RDPIX, 1023, -1024);
		send_command(mfde_pkg::KIND_RDBYTE, -1024, 1023);
		send_command(4'd15, -1, -1, -1, -1, 1023, 1023, 63, 255);
		send_command(mfde_pkg::KIND_RDBYTE, 72, 51);
		send_command(mfde_pkg::KIND_CLEAR, 0, 0);
		send_command(mfde_pkg::KIND_RDBYTE, 0, 0);
		wait_drained();
	endtask

	task automatic test_phase(int idle, int stall, int n);
		idle_pct  = idle;
		stall_pct = stall;
		for (int i = 0; i < n; i++)
			send_random_command();
	endtask

	task automatic test_hold_off();
		idle_pct  = 0;
		stall_pct = 0;
		hold_off  = 1'b1;
		for (int i = 0; i < 40; i++)
			send_random_command();
		wait_drained();
		read_back_rows(10);
	endtask

	// --------------------------------------------------------------- receiver
	always @(negedge clk) begin
		int held;
		if (hold_off && held < 600) begin
			held++;
			out_stall <= 1'b1;
		end else begin
			if (hold_off) begin
				hold_off = 1'b0;
				held = 0;
			end
			out_stall <= stall_pct > 0 && $urandom_range(99) < stall_pct;
		end
	end

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("mismatch: %s got %0h expected %0h", what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_values.size() == 0)
				report_mismatch("unexpected read_value", read_value, 8'h00);
			else if (read_value !== expected_values[0])
				report_mismatch("read_value", read_value, expected_values.pop_front());
			else
				void'(expected_values.pop_front());
		end
	end

	// watchdog: counts cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WatchdogLimit) begin
			$display("mono_framebuffer_draw_engine_tb NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		kind = '0; pos_x = '0; pos_y = '0; end_x = '0; end_y = '0;
		size_w = '0; size_h = '0; radius = '0; glyph_code = '0;
		idle_pct = 0; stall_pct = 0; hold_off = 1'b0;
		mismatch_count = 0; quiet_cycles = 0;
		for (int i = 0; i < mfde_pkg::StoreBytes; i++) shadow_store[i] = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_phase(0, 0, 400);
		test_hold_off();
		test_phase(77, 0, 300);
		test_phase(0, 77, 300);
		test_phase(34, 34, 300);
		test_phase(0, 0, 300);
		wait_drained();
		idle_pct = 0;
		stall_pct = 0;
		repeat (DrainCycles) @(negedge clk);
		if (mismatch_count == 0 && expected_values.size() == 0)
			$display("mono_framebuffer_draw_engine_tb OK");
		else
			$display("mono_framebuffer_draw_engine_tb NOT OK");
		$finish;
	end

endmodule
